// ----- sv/slac_pkg.sv -----
// Shared types and constants for the stereo linked audio compressor.
// Holds the datapath command set, the configuration record and the
// square-root-of-two constant table. No dependencies.
package slac_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_SLOPE     = 3'd2;
  localparam logic [2:0] REG_ATTACK    = 3'd3;
  localparam logic [2:0] REG_RELEASE   = 3'd4;
  localparam logic [2:0] REG_MAKEUP    = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // 6.0206 dB per octave, times 256, in Q16, and the inverse of 6.0206 in Q16.
  localparam logic [26:0] DB_OCT_Q16     = 27'd101008905;
  localparam logic [13:0] INV_DB_OCT_Q16 = 14'd10885;
  // Level given to a silent item: -144 dB in 1/256 dB.
  localparam logic signed [17:0] FLOOR_DB = -18'sd36864;

  localparam int EXP_STEPS = 16;
  localparam int CNT_W     = 4;

  typedef logic [31:0] root_arr_t [EXP_STEPS];

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_PEAK   = 4'd2,
    OP_NORM   = 4'd3,
    OP_LOG    = 4'd4,
    OP_LEVEL  = 4'd5,
    OP_RED    = 4'd6,
    OP_ENV1   = 4'd7,
    OP_ENV2   = 4'd8,
    OP_GAIN   = 4'd9,
    OP_EXP    = 4'd10,
    OP_APPLY1 = 4'd11,
    OP_APPLY2 = 4'd12,
    OP_OUT    = 4'd13
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic               enable;
    logic signed [16:0] threshold_db;
    logic [16:0]        compress_slope;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
    logic signed [13:0] makeup_db;
  } cfg_t;

  // Integer square root, bit by bit.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bit_v;
    res   = '0;
    rem   = v;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Successive roots of two in Q1.30: entry k is 2^(2^-(k+1)).
  function automatic root_arr_t calc_roots();
    root_arr_t   tab;
    logic [63:0] root;
    root = 64'h8000_0000;
    for (int k = 0; k < EXP_STEPS; k++) begin
      root   = isqrt64(root << 30);
      tab[k] = root[31:0];
    end
    return tab;
  endfunction

  localparam root_arr_t ROOTS = calc_roots();

endpackage

// ----- sv/slac_in_if.sv -----
// Input channel of the compressor: one stereo sample pair per item.
// Valid/ready handshake; no package dependency.
interface slac_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- sv/slac_out_if.sv -----
// Output channel of the compressor: one processed stereo pair per item.
// Valid/ready handshake; no package dependency.
interface slac_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- sv/slac_ctrl.sv -----
// Sequencing controller of the compressor: steps the datapath one operation
// per cycle while it is not waiting for input or for the output register, and owns both handshakes. Uses slac_pkg.
module slac_ctrl import slac_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    enable_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_PEAK   = 13'b0000000000010,
    S_NORM   = 13'b0000000000100,
    S_LOG    = 13'b0000000001000,
    S_LEVEL  = 13'b0000000010000,
    S_RED    = 13'b0000000100000,
    S_ENV1   = 13'b0000001000000,
    S_ENV2   = 13'b0000010000000,
    S_GAIN   = 13'b0000100000000,
    S_EXP    = 13'b0001000000000,
    S_APPLY1 = 13'b0010000000000,
    S_APPLY2 = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

  localparam logic [CNT_W-1:0] LogLast = CNT_W'(LOG_TABLE_BITS - 1);
  localparam logic [CNT_W-1:0] ExpLast = CNT_W'(EXP_STEPS - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state, step counter and command.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = enable_i ? S_PEAK : S_DONE;
        end
      end
      S_PEAK: begin
        cmd_o.op = OP_PEAK;
        state_d  = S_NORM;
      end
      S_NORM: begin
        cmd_o.op = OP_NORM;
        cnt_d    = '0;
        state_d  = S_LOG;
      end
      S_LOG: begin
        cmd_o.op = OP_LOG;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == LogLast) begin
          state_d = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd_o.op = OP_LEVEL;
        state_d  = S_RED;
      end
      S_RED: begin
        cmd_o.op = OP_RED;
        state_d  = S_ENV1;
      end
      S_ENV1: begin
        cmd_o.op = OP_ENV1;
        state_d  = S_ENV2;
      end
      S_ENV2: begin
        cmd_o.op = OP_ENV2;
        state_d  = S_GAIN;
      end
      S_GAIN: begin
        cmd_o.op = OP_GAIN;
        cnt_d    = '0;
        state_d  = S_EXP;
      end
      S_EXP: begin
        cmd_o.op = OP_EXP;
        cnt_d    = cnt_q + CNT_W'(1);
        if (cnt_q == ExpLast) begin
          state_d = S_APPLY1;
        end
      end
      S_APPLY1: begin
        cmd_o.op = OP_APPLY1;
        state_d  = S_APPLY2;
      end
      S_APPLY2: begin
        cmd_o.op = OP_APPLY2;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted item did not start processing");

  // A finished item with a free output register is shown in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not delivered to output register");

  // The log iteration count never runs past the fraction width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOG) |-> (cnt_q <= LogLast))
    else $error("log step counter out of range");

  // The exponent stage always hands over to the gain multiply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXP && cnt_q == ExpLast) |=> (state_q == S_APPLY1))
    else $error("exponent stage did not finish");

endmodule

// ----- sv/slac_dp.sv -----
// Arithmetic datapath of the compressor: level detector, gain computer,
// envelope follower and gain stage, driven one operation per cycle.
// Uses slac_pkg for commands, configuration record and constants.
module slac_dp import slac_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dp_cmd_t                        cmd_i,
  input  cfg_t                           cfg_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0] right_out_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int LTB = LOG_TABLE_BITS;
  localparam int EW  = $clog2(SW);
  localparam int NW  = EW + LTB;
  localparam int PW  = NW + 27;
  localparam logic [SW-1:0] MagLimit = SW'(1) << (SW - 1);
  localparam logic [SW-1:0] MaxPos   = MagLimit - SW'(1);

  logic signed [SW-1:0] sl_q, sr_q, res_l_q, res_r_q, out_l_q, out_r_q;
  logic                 bypass_q;
  logic [SW-1:0]        peak_q;
  logic                 zero_q;
  logic [EW-1:0]        e_q;
  logic [30:0]          m_q;
  logic [LTB-1:0]       frac_q;
  logic signed [17:0]   lvl_q;
  logic [26:0]          target_q;
  logic [15:0]          c_q;
  logic [47:0]          acc_q;
  logic [31:0]          env_q;
  logic signed [15:0]   n_q;
  logic [15:0]          f_q;
  logic [31:0]          r_q;
  logic [63:0]          prod_l_q, prod_r_q;

  // Combinational helpers.
  logic [SW-1:0]        abs_l, abs_r, peak_c;
  logic [EW-1:0]        e_c;
  logic [61:0]          sq;
  logic [31:0]          sq_top;
  logic [EW-1:0]        ediff;
  logic [NW-1:0]        neg;
  logic [PW-1:0]        lvl_prod;
  logic signed [18:0]   diff;
  logic [34:0]          red_prod;
  logic [48:0]          env_sum;
  logic signed [33:0]   x;
  logic signed [47:0]   lq_prod;
  logic [63:0]          exp_prod;
  logic [63:0]          exp_sum;
  logic signed [17:0]   sh;
  logic [5:0]           amt;
  logic                 kill;

  function automatic logic [SW-1:0] magnitude(input logic signed [SW-1:0] s);
    return s[SW-1] ? SW'(-s) : SW'(s);
  endfunction

  // Round, shift and saturate one scaled magnitude, then restore the sign.
  function automatic logic [SW-1:0] finish(input logic [63:0] p, input logic sgn,
                                           input logic [5:0] sa, input logic zero_out);
    logic [64:0] rnd;
    logic [64:0] shifted;
    logic [SW-1:0] mag;
    rnd     = {1'b0, p} + (65'd1 << (sa - 6'd1));
    shifted = rnd >> sa;
    if (zero_out) begin
      mag = '0;
    end else if (shifted > 65'(MagLimit)) begin
      mag = MagLimit;
    end else begin
      mag = shifted[SW-1:0];
    end
    if (sgn) begin
      return SW'(-mag);
    end else if (mag > MaxPos) begin
      return MaxPos;
    end
    return mag;
  endfunction

  assign abs_l  = magnitude(sl_q);
  assign abs_r  = magnitude(sr_q);
  assign peak_c = (abs_l > abs_r) ? abs_l : abs_r;

  // Index of the leading one of the peak.
  always_comb begin
    e_c = '0;
    for (int i = 0; i < SW; i++) begin
      if (peak_q[i]) begin
        e_c = EW'(i);
      end
    end
  end

  assign sq     = 62'(m_q) * 62'(m_q);
  assign sq_top = sq[61:30];

  assign ediff    = EW'(SW - 1) - e_q;
  assign neg      = {ediff, {LTB{1'b0}}} - NW'(frac_q);
  assign lvl_prod = PW'(neg) * PW'(DB_OCT_Q16) + (PW'(1) << (LTB + 15));

  assign diff     = 19'(lvl_q) - 19'(cfg_i.threshold_db);
  assign red_prod = 35'(diff[17:0]) * 35'(cfg_i.compress_slope);

  assign env_sum  = 49'(acc_q) + 49'(17'(18'd65536 - 18'(c_q))) * 49'(target_q)
                  + 49'd32768;

  assign x        = (34'(cfg_i.makeup_db) <<< 8) - $signed({2'b00, env_q});
  assign lq_prod  = 48'(x) * $signed({34'd0, INV_DB_OCT_Q16});

  assign exp_prod = 64'(r_q) * 64'(ROOTS[cmd_i.idx]);
  assign exp_sum  = exp_prod + (64'd1 << 29);

  // Output shift: 30 - n, no less than one; far attenuation gives zero.
  assign sh   = 18'sd30 - 18'(n_q);
  assign kill = (sh >= 18'sd63);
  assign amt  = (sh < 18'sd1) ? 6'd1 : (kill ? 6'd1 : sh[5:0]);

  // Envelope register: the only state with a defined reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (cmd_i.op == OP_ENV2) begin
      env_q <= env_sum[47:16];
    end
  end

  // Working registers, updated by the current operation.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sl_q     <= left_sample_i;
        sr_q     <= right_sample_i;
        bypass_q <= !cfg_i.enable;
      end
      OP_PEAK: begin
        peak_q <= peak_c;
        zero_q <= (peak_c == '0);
      end
      OP_NORM: begin
        e_q    <= e_c;
        m_q    <= 31'((64'(peak_q) << 30) >> e_c);
        frac_q <= '0;
      end
      OP_LOG: begin
        if (sq_top[31]) begin
          m_q    <= sq_top[31:1];
          frac_q <= {frac_q[LTB-2:0], 1'b1};
        end else begin
          m_q    <= sq_top[30:0];
          frac_q <= {frac_q[LTB-2:0], 1'b0};
        end
      end
      OP_LEVEL: begin
        lvl_q <= zero_q ? FLOOR_DB : -$signed({1'b0, 17'(lvl_prod >> (LTB + 16))});
      end
      OP_RED: begin
        target_q <= (diff > 19'sd0) ? {red_prod[34:16], 8'd0} : '0;
      end
      OP_ENV1: begin
        c_q   <= (32'(target_q) > env_q) ? cfg_i.attack_coeff : cfg_i.release_coeff;
        acc_q <= 48'((32'(target_q) > env_q) ? cfg_i.attack_coeff : cfg_i.release_coeff)
               * 48'(env_q);
      end
      OP_GAIN: begin
        n_q <= lq_prod[47:32];
        f_q <= lq_prod[31:16];
        r_q <= 32'h4000_0000;
      end
      OP_EXP: begin
        if (f_q[4'd15 - cmd_i.idx]) begin
          r_q <= 32'(exp_sum >> 30);
        end
      end
      OP_APPLY1: begin
        prod_l_q <= 64'(abs_l) * 64'(r_q);
        prod_r_q <= 64'(abs_r) * 64'(r_q);
      end
      OP_APPLY2: begin
        res_l_q <= finish(prod_l_q, sl_q[SW-1], amt, kill);
        res_r_q <= finish(prod_r_q, sr_q[SW-1], amt, kill);
      end
      OP_OUT: begin
        out_l_q <= bypass_q ? sl_q : res_l_q;
        out_r_q <= bypass_q ? sr_q : res_r_q;
      end
      default: begin
      end
    endcase
  end

  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule

// ----- sv/stereo_linked_audio_compressor_top.sv -----
// Top level of the stereo linked feedforward hard-knee compressor.
// Holds the configuration registers and joins controller and datapath.
// Uses slac_pkg, slac_in_if, slac_out_if, slac_ctrl and slac_dp.
//
//   Channel  Direction  Contents
//   in_i     sink       left_sample, right_sample (one stereo pair per item)
//   out_o    source     left_out, right_out (one processed pair per item)
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// An enabled item passes from acceptance to the output register through the
// log squaring loop, one step per fraction bit, and the 16-step exponent loop,
// each loop with its own multiplier. A bypassed item goes from the idle state
// straight to the done state. One item is in work at a time; the output
// register holds a result while the next item is accepted and processed.
// Reset clears the envelope, the handshake state and the registers to defaults.
module stereo_linked_audio_compressor_top import slac_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slac_in_if.sink               in_i,
  slac_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  dp_cmd_t cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.threshold_db   <= -17'sd5120;
      cfg_q.compress_slope <= 17'd49152;
      cfg_q.attack_coeff   <= 16'd65000;
      cfg_q.release_coeff  <= 16'd65500;
      cfg_q.makeup_db      <= 14'sd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:    cfg_q.enable         <= cfg_wdata_i[0];
        REG_THRESHOLD: cfg_q.threshold_db   <= cfg_wdata_i;
        REG_SLOPE:     cfg_q.compress_slope <= cfg_wdata_i;
        REG_ATTACK:    cfg_q.attack_coeff   <= cfg_wdata_i[15:0];
        REG_RELEASE:   cfg_q.release_coeff  <= cfg_wdata_i[15:0];
        REG_MAKEUP:    cfg_q.makeup_db      <= cfg_wdata_i[13:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  slac_ctrl #(
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .enable_i   (cfg_q.enable),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd)
  );

  // Arithmetic.
  slac_dp #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .LOG_TABLE_BITS(LOG_TABLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_q),
    .left_sample_i (in_i.left_sample),
    .right_sample_i(in_i.right_sample),
    .left_out_o    (out_o.left_out),
    .right_out_o   (out_o.right_out)
  );

endmodule

// ----- tb/sv/tb_stereo_linked_audio_compressor_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the stereo linked audio compressor top level.
// Depends on slac_pkg, slac_in_if, slac_out_if and stereo_linked_audio_compressor_top;
// a built-in gain predictor works out every processed sample pair.
module tb_stereo_linked_audio_compressor_top;
  import slac_pkg::*;

  localparam int SW          = 24;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [SW-1:0] left_out;
    logic signed [SW-1:0] right_out;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  slac_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  slac_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  stereo_linked_audio_compressor_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the configuration and the gain envelope.
  logic        sh_enable;
  logic [16:0] sh_threshold;
  logic [16:0] sh_slope;
  logic [15:0] sh_attack;
  logic [15:0] sh_release;
  logic [13:0] sh_makeup;
  logic [31:0] sh_envelope;

  longint unsigned root_q30 [16];
  pair_t       expected_pairs [$];
  int          fail_count = 0;
  int          pairs_checked = 0;
  int          pairs_sent = 0;
  int          reg_writes = 0;
  longint      cycle_count = 0;
  int          out_stall_left = 0;

  always #5 clk_i = ~clk_i;

  // Cycle counter guarding against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_pairs.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Gap length for either side: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bit_v;
    res   = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v   = v - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Peak level in 1/256 dB relative to full scale.
  function automatic longint peak_level(longint unsigned p);
    int unsigned     e;
    longint unsigned m;
    longint unsigned frac;
    longint          lg;
    longint unsigned neg;
    if (p == 0) return -36864;
    e = 0;
    while ((p >> (e + 1)) != 0) e++;
    m    = (e <= 30) ? (p << (30 - e)) : (p >> (e - 30));
    frac = 0;
    for (int i = 0; i < 8; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m    = m >> 1;
        frac = frac | 1;
      end
    end
    lg  = (longint'(e) - (SW - 1)) * 256 + longint'(frac);
    neg = longint'(-lg);
    return -longint'((neg * 64'd101008905 + (64'd1 << 23)) >> 24);
  endfunction

  // 2^(f/65536) in Q1.30 from the chain of roots of two.
  function automatic longint unsigned frac_pow2(longint unsigned f);
    longint unsigned r;
    r = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if ((f >> (15 - k)) & 1) r = (r * root_q30[k] + (64'd1 << 29)) >> 30;
    return r;
  endfunction

  function automatic logic [SW-1:0] scale_sample(longint s, longint unsigned g, longint n);
    longint          maxv;
    longint          sh;
    longint          v;
    longint unsigned mag;
    maxv = (64'd1 << (SW - 1)) - 1;
    sh   = 30 - n;
    mag  = longint'(s < 0 ? -s : s) * g;
    if (sh < 1) sh = 1;
    if (sh >= 63) mag = 0;
    else mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (mag > longint'(maxv) + 1) mag = maxv + 1;
    v = (s < 0) ? -longint'(mag) : longint'(mag);
    if (v > maxv) v = maxv;
    return v[SW-1:0];
  endfunction

  // Works out one processed pair and advances the envelope.
  function automatic pair_t compress_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    pair_t           res;
    longint          sl;
    longint          sr;
    longint unsigned peak;
    longint          lvl;
    longint          thr;
    longint unsigned red;
    longint unsigned target;
    longint unsigned c;
    longint unsigned env;
    longint          x;
    longint          lq;
    longint          n;
    longint unsigned g;
    if (!sh_enable) begin
      res.left_out  = l;
      res.right_out = r;
      return res;
    end
    sl   = l;
    sr   = r;
    peak = (sl < 0 ? -sl : sl);
    if ((sr < 0 ? -sr : sr) > peak) peak = (sr < 0 ? -sr : sr);
    lvl = peak_level(peak);
    thr = longint'($signed(sh_threshold));
    red = 0;
    if (lvl > thr) red = (longint'(lvl - thr) * longint'(sh_slope)) >> 16;
    target = red << 8;
    env    = sh_envelope;
    c      = (target > env) ? sh_attack : sh_release;
    env    = (c * env + (65536 - c) * target + 32768) >> 16;
    sh_envelope = env[31:0];
    x  = longint'($signed(sh_makeup)) * 256 - longint'(env);
    lq = (x * 10885) >>> 16;
    n  = lq >>> 16;
    g  = frac_pow2(longint'(lq - n * 65536));
    res.left_out  = scale_sample(sl, g, n);
    res.right_out = scale_sample(sr, g, n);
    return res;
  endfunction

  // Output side: random back-pressure.
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ch.ready   <= 1'b0;
    end else begin
      out_stall_left <= pick_gap();
      out_ch.ready   <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected pair.
  always @(posedge clk_i) begin
    pair_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result L=%0d R=%0d", $time, out_ch.left_out,
                 out_ch.right_out);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        pairs_checked++;
        if (out_ch.left_out !== want.left_out) begin
          $display("%0t: left_out expected %0d actual %0d", $time, want.left_out,
                   out_ch.left_out);
          fail_count++;
        end
        if (out_ch.right_out !== want.right_out) begin
          $display("%0t: right_out expected %0d actual %0d", $time, want.right_out,
                   out_ch.right_out);
          fail_count++;
        end
      end
    end
  end

  // Sends one sample pair; the prediction is made at acceptance.
  task automatic send_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_pairs.push_back(compress_pair(l, r));
    pairs_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write; the block must be idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENABLE:    sh_enable    = val[0];
      REG_THRESHOLD: sh_threshold = val[16:0];
      REG_SLOPE:     sh_slope     = val[16:0];
      REG_ATTACK:    sh_attack    = val[15:0];
      REG_RELEASE:   sh_release   = val[15:0];
      REG_MAKEUP:    sh_makeup    = val[13:0];
      default: ;
    endcase
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic write_all(logic en, int thr, int slope, int att, int rel, int mk);
    write_reg(REG_ENABLE, 17'(en));
    write_reg(REG_THRESHOLD, 17'(thr));
    write_reg(REG_SLOPE, 17'(slope));
    write_reg(REG_ATTACK, 17'(att));
    write_reg(REG_RELEASE, 17'(rel));
    write_reg(REG_MAKEUP, 17'(mk));
  endtask

  // Sample with a random level spread over the whole dB range.
  function automatic logic signed [SW-1:0] rand_sample(int loud);
    logic signed [SW-1:0] s;
    s = SW'($urandom);
    if (loud) return s;
    return s >>> $urandom_range(1, SW - 1);
  endfunction

  // Bypass passes samples through; field extremes included.
  task automatic test_bypass();
    wait_drained();
    write_reg(REG_ENABLE, 17'd0);
    send_pair(24'sh7FFFFF, -24'sh800000);
    send_pair(-24'sh800000, 24'sh7FFFFF);
    send_pair(24'sd0, -24'sd1);
    for (int i = 0; i < 5; i++) send_pair(rand_sample(1), rand_sample(1));
  endtask

  // Directed corners: silence, full scale, most negative sample, register extremes.
  task automatic test_corners();
    wait_drained();
    write_all(1'b1, -5120, 49152, 65000, 65500, 0);
    send_pair(24'sd0, 24'sd0);
    send_pair(24'sd1, -24'sd1);
    send_pair(-24'sh800000, 24'sd0);
    send_pair(24'sh7FFFFF, 24'sh7FFFFF);
    // Fastest attack, hardest ratio, lowest threshold: deep attenuation.
    wait_drained();
    write_all(1'b1, -36864, 65536, 0, 0, -6144);
    send_pair(-24'sh800000, 24'sh7FFFFF);
    send_pair(24'sh400000, 24'sd3);
    send_pair(24'sd0, 24'sd0);
    // No compression with full makeup: the loud pairs saturate.
    wait_drained();
    write_all(1'b1, 0, 0, 65535, 65535, 6144);
    send_pair(24'sh7FFFFF, -24'sh800000);
    send_pair(24'sh100000, -24'sh100000);
    send_pair(24'sd1, -24'sd2);
    // Register bits beyond the nominal ranges.
    wait_drained();
    write_all(1'b1, 17'h0FFFF, 17'h1FFFF, 3, 65535, 14'h1FFF);
    send_pair(24'sh7FFFFF, 24'sd5);
    send_pair(24'sd5, -24'sh7FFFF0);
    wait_drained();
    write_all(1'b1, 17'h10000, 17'h1FFFF, 0, 1, 14'h2000);
    send_pair(24'sh7FFFFF, 24'sd5);
    send_pair(24'sd0, 24'sd1);
  endtask

  // Random phases: loud bursts and quiet stretches drive attack and release.
  task automatic test_random_phases(int total);
    int left_n;
    int seg;
    int loud;
    left_n = total;
    for (int ph = 0; left_n > 0; ph++) begin
      wait_drained();
      if (ph % 5 == 4)
        write_all(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        write_all(($urandom_range(0, 9) != 0), -$urandom_range(0, 36864),
                  $urandom_range(0, 65536), $urandom_range(60000, 65535),
                  $urandom_range(60000, 65535), $urandom_range(0, 12288) - 6144);
      for (int k = 0; k < 200 && left_n > 0; k += seg) begin
        seg  = $urandom_range(5, 40);
        loud = $urandom_range(0, 1);
        for (int j = 0; j < seg; j++) begin
          send_pair(rand_sample(loud), rand_sample(loud));
          left_n--;
        end
        // Occasionally hold off until every result is back.
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    longint unsigned rt;
    rt = 64'd2 << 30;
    for (int k = 0; k < 16; k++) begin
      rt = int_sqrt(rt << 30);
      root_q30[k] = rt;
    end
    sh_enable    = 1'b0;
    sh_threshold = 17'h1EC00;
    sh_slope     = 17'd49152;
    sh_attack    = 16'd65000;
    sh_release   = 16'd65500;
    sh_makeup    = '0;
    sh_envelope  = '0;
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    out_ch.ready       = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_bypass();
    test_corners();
    test_random_phases(1500);

    in_ch.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d sample pairs, checked %0d results, %0d register writes.",
             pairs_sent, pairs_checked, reg_writes);
    $display("Covered bypass, field extremes, register extremes and random envelopes.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/slac_pkg.sv
sv/slac_in_if.sv
sv/slac_out_if.sv
sv/slac_ctrl.sv
sv/slac_dp.sv
sv/stereo_linked_audio_compressor_top.sv
tb/sv/tb_stereo_linked_audio_compressor_top.sv
